[src/first_fit_block_allocator_top_defines.svh]
// Assertion macros for the first-fit block allocator.
// Used at the end of the top level; clk and rst_n must be in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ffa_pkg.sv]
// Shared types and constants of the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned STORE_AW  = 16;
  localparam int unsigned HDR_BYTES = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_t;

  // Status from the sequencer, watched at the top level.
  typedef struct packed {
    logic    load;
    logic    list_full;
    status_t load_status;
  } mon_t;

endpackage

`default_nettype wire

[src/first_fit_block_allocator_top.sv]
// First-fit variable-size block allocator: the sequencer, the free-list RAM
// and the block header RAM. Depends on ffa_pkg, ffa_ram, ffa_ctrl and the defines header.
//
// Input channel in_*: one beat carries func (0 allocate, 1 free), size and addr.
// Output channel out_*: exactly one beat per input beat, in order, with the
// allocated data offset (zero on free or failure) and a status code.
// One item is in work at a time; in_stall is high from acceptance until its
// result is moved into the output register. The output register lets the next
// item be taken while an earlier result still waits on out_stall.
// A free appends its address to the free list when there is room. An allocate
// scans the list from entry 0, a list RAM read and then a header RAM read of that
// entry per entry; on a hit it splits the block or, on a whole take, closes the
// gap behind the hit; on a miss or an empty list it bumps. The registered reads
// of the two RAMs set the scan pace.
// A stalled receiver holds the result; a finished item then waits in the
// sequencer until the output register frees up.
// Reset (synchronous, rst_n low) empties the free list and rewinds the bump
// pointer; RAM contents are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_block_allocator_top_defines.svh"

module first_fit_block_allocator_top #(
  parameter int unsigned ARENA_BYTES = 65536,
  parameter int unsigned FREE_SLOTS  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [15:0] in_size,
  input  wire logic [15:0] in_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_addr_res,
  output logic [1:0]       out_status
);

  import ffa_pkg::*;

  localparam int unsigned IW = $clog2(FREE_SLOTS);

  logic                lst_we;
  logic [IW-1:0]       lst_waddr;
  logic [DATA_W-1:0]   lst_wdata;
  logic [IW-1:0]       lst_raddr;
  logic [DATA_W-1:0]   lst_rdata;
  logic                sz_we;
  logic [STORE_AW-1:0] sz_waddr;
  logic [DATA_W-1:0]   sz_wdata;
  logic [STORE_AW-1:0] sz_raddr;
  logic [DATA_W-1:0]   sz_rdata;
  mon_t                mon;
  logic                full_load;
  logic                fail_beat;

  ffa_ram #(
    .AW(IW),
    .DW(DATA_W)
  ) u_list_ram (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (lst_wdata),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  ffa_ram #(
    .AW(STORE_AW),
    .DW(DATA_W)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  ffa_ctrl #(
    .ARENA_BYTES(ARENA_BYTES),
    .FREE_SLOTS (FREE_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_size      (in_size),
    .in_addr      (in_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_addr_res (out_addr_res),
    .out_status   (out_status),
    .lst_we       (lst_we),
    .lst_waddr    (lst_waddr),
    .lst_wdata    (lst_wdata),
    .lst_raddr    (lst_raddr),
    .lst_rdata    (lst_rdata),
    .sz_we        (sz_we),
    .sz_waddr     (sz_waddr),
    .sz_wdata     (sz_wdata),
    .sz_raddr     (sz_raddr),
    .sz_rdata     (sz_rdata),
    .mon          (mon)
  );

  assign full_load = mon.load && (mon.load_status == ST_LIST_FULL);
  assign fail_beat = out_valid && (out_status != ST_OK);

  `FFA_ASSERT_IMP(a_load_slot, mon.load, !out_valid || !out_stall, "result overwrote a held beat")
  `FFA_ASSERT_NXT(a_load_valid, mon.load, out_valid, "loaded result not presented")
  `FFA_ASSERT_IMP(a_full_status, full_load, mon.list_full, "list full status with room left")
  `FFA_ASSERT_IMP(a_fail_zero, fail_beat, out_addr_res == '0, "failed beat carries an address")

endmodule

`default_nettype wire

[src/ffa_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffa_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/ffa_ctrl.sv]
// Sequencer of the allocator: free-list scan, split, drop-and-shift, bump path
// and the result register. Drives the free-list RAM and the header RAM; uses ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl #(
  parameter int unsigned ARENA_BYTES = 65536,
  parameter int unsigned FREE_SLOTS  = 256,
  localparam int unsigned IW = $clog2(FREE_SLOTS),
  localparam int unsigned CW = $clog2(FREE_SLOTS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_func,
  input  wire logic [15:0]             in_size,
  input  wire logic [15:0]             in_addr,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [15:0]                  out_addr_res,
  output logic [1:0]                   out_status,
  output logic                         lst_we,
  output logic [IW-1:0]                lst_waddr,
  output logic [15:0]                  lst_wdata,
  output logic [IW-1:0]                lst_raddr,
  input  wire logic [15:0]             lst_rdata,
  output logic                         sz_we,
  output logic [15:0]                  sz_waddr,
  output logic [15:0]                  sz_wdata,
  output logic [15:0]                  sz_raddr,
  input  wire logic [15:0]             sz_rdata,
  output ffa_pkg::mon_t                mon
);

  import ffa_pkg::*;

  localparam int unsigned BW = $clog2(ARENA_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_CMP,
    S_SPLIT,
    S_SHIFT,
    S_BUMP,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] bump_r, bump_nxt;
  logic [15:0]   req_r, req_nxt;
  logic [15:0]   obj_r, obj_nxt;
  logic [15:0]   moved_r, moved_nxt;
  logic [15:0]   rest_r, rest_nxt;
  logic [15:0]   res_addr_r, res_addr_nxt;
  status_t       res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_addr_r, out_addr_nxt;
  status_t       out_status_r, out_status_nxt;

  logic          slot_free;
  logic          load;
  logic [CW:0]   idx_w;
  logic [CW:0]   cnt_w;
  logic [16:0]   req_hdr;
  logic [15:0]   moved;
  logic [15:0]   rest;
  logic [17:0]   bump_data;
  logic [17:0]   bump_end;
  logic          bump_fail;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = (state_r == S_FINISH) && slot_free;
  assign idx_w     = (CW + 1)'(idx_r);
  assign cnt_w     = (CW + 1)'(cnt_r);
  assign req_hdr   = {1'b0, req_r} + 17'(HDR_BYTES);
  assign moved     = obj_r + req_r + 16'(HDR_BYTES);
  assign rest      = sz_rdata - req_r - 16'(HDR_BYTES);
  assign bump_data = 18'(bump_r) + 18'(HDR_BYTES);
  assign bump_end  = bump_data + 18'(req_r);
  assign bump_fail = (bump_end > 18'(ARENA_BYTES)) || (bump_data >= 18'(ARENA_BYTES));

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_addr_res = out_addr_r;
  assign out_status   = out_status_r;

  assign mon.load        = load;
  assign mon.list_full   = (cnt_r == CW'(FREE_SLOTS));
  assign mon.load_status = res_status_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    bump_nxt       = bump_r;
    req_nxt        = req_r;
    obj_nxt        = obj_r;
    moved_nxt      = moved_r;
    rest_nxt       = rest_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    lst_we         = 1'b0;
    lst_waddr      = idx_r;
    lst_wdata      = lst_rdata;
    lst_raddr      = idx_r;
    sz_we          = 1'b0;
    sz_waddr       = obj_r;
    sz_wdata       = req_r;
    sz_raddr       = lst_rdata;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_size;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          idx_nxt        = '0;
          if (in_func == FUNC_FREE) begin
            if (cnt_r == CW'(FREE_SLOTS)) begin
              res_status_nxt = ST_LIST_FULL;
            end else begin
              lst_we    = 1'b1;
              lst_waddr = IW'(cnt_r);
              lst_wdata = in_addr;
              cnt_nxt   = cnt_r + CW'(1);
            end
            state_nxt = S_FINISH;
          end else if (cnt_r == '0) begin
            state_nxt = S_BUMP;
          end else begin
            lst_raddr = '0;
            state_nxt = S_HDR;
          end
        end
      end
      S_HDR: begin
        // list entry is back: fetch its header
        obj_nxt   = lst_rdata;
        sz_raddr  = lst_rdata;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (req_r <= sz_rdata) begin
          res_addr_nxt = obj_r;
          if ({1'b0, sz_rdata} > req_hdr) begin
            // split: shrink this header, move entry up to the remainder
            sz_we     = 1'b1;
            sz_waddr  = obj_r;
            sz_wdata  = req_r;
            lst_we    = 1'b1;
            lst_waddr = idx_r;
            lst_wdata = moved;
            moved_nxt = moved;
            rest_nxt  = rest;
            state_nxt = S_SPLIT;
          end else if (idx_w + (CW + 1)'(1) < cnt_w) begin
            lst_raddr = IW'(idx_w + (CW + 1)'(1));
            state_nxt = S_SHIFT;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_FINISH;
          end
        end else if (idx_w + (CW + 1)'(1) < cnt_w) begin
          idx_nxt   = idx_r + IW'(1);
          lst_raddr = idx_r + IW'(1);
          state_nxt = S_HDR;
        end else begin
          state_nxt = S_BUMP;
        end
      end
      S_SPLIT: begin
        sz_we     = 1'b1;
        sz_waddr  = moved_r;
        sz_wdata  = rest_r;
        state_nxt = S_FINISH;
      end
      S_SHIFT: begin
        // close the gap: entry k+1 lands in k, fetch k+2 meanwhile
        lst_we    = 1'b1;
        lst_waddr = idx_r;
        lst_wdata = lst_rdata;
        if (idx_w + (CW + 1)'(2) < cnt_w) begin
          lst_raddr = IW'(idx_w + (CW + 1)'(2));
          idx_nxt   = idx_r + IW'(1);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FINISH;
        end
      end
      S_BUMP: begin
        if (bump_fail) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_EXHAUSTED;
        end else begin
          sz_we        = 1'b1;
          sz_waddr     = bump_data[15:0];
          sz_wdata     = req_r;
          bump_nxt     = BW'(bump_end);
          res_addr_nxt = bump_data[15:0];
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    obj_r        <= obj_nxt;
    moved_r      <= moved_nxt;
    rest_r       <= rest_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire
